### hdl/pcxl_pkg.sv
package pcxl_pkg;

  // image limits and file layout
  localparam int MAX_DIM       = 1024;
  localparam int MAX_CODES     = 1048576;
  localparam int HEADER_BYTES  = 128;
  localparam int PALETTE_BYTES = 768;

  // derived widths
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PIX_W  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int CODE_W = $clog2(MAX_CODES + 1);
  localparam int POS_W  = $clog2(PALETTE_BYTES);
  localparam int SIZE_W = 17;
  localparam int RUN_W  = 6;

  // signature bytes, first byte in the low lane
  localparam logic [31:0] SIG_WORD = 32'h0801050a;
  localparam logic [1:0]  RUN_MARK = 2'b11;

  // header byte positions
  localparam logic [POS_W-1:0] POS_SIG_END = POS_W'(3);
  localparam logic [POS_W-1:0] POS_XLO     = POS_W'(8);
  localparam logic [POS_W-1:0] POS_XHI     = POS_W'(9);
  localparam logic [POS_W-1:0] POS_YLO     = POS_W'(10);
  localparam logic [POS_W-1:0] POS_YHI     = POS_W'(11);
  localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_PAL_END = POS_W'(PALETTE_BYTES - 1);

  // command queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CODE,
    PH_VALUE,
    PH_SKIP,
    PH_PALETTE
  } phase_t;

  typedef enum logic [2:0] {
    K_HEADER  = 3'd0,
    K_PIXEL   = 3'd1,
    K_PALETTE = 3'd2,
    K_BADSIG  = 3'd3,
    K_TOOBIG  = 3'd4
  } kind_t;

  // one queued command: a result repeated cnt times
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        value;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [RUN_W-1:0]  cnt;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### hdl/pcxl_front.sv
module pcxl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  logic               start_of_file,
  input  logic [7:0]         byte_value,
  input  pcxl_pkg::q_status_t q_status,
  output logic               cmd_wr,
  output pcxl_pkg::cmd_t     cmd
);

  pcxl_pkg::phase_t                  phase, phase_e, phase_next;
  logic [pcxl_pkg::POS_W-1:0]        pos, pos_e, pos_next;
  logic [pcxl_pkg::SIZE_W-1:0]       img_w, img_w_e, img_w_next;
  logic [pcxl_pkg::SIZE_W-1:0]       img_h, img_h_e, img_h_next;
  logic [pcxl_pkg::PIX_W-1:0]        pix_left, pix_left_e, pix_left_next;
  logic [pcxl_pkg::CODE_W-1:0]       codes, codes_e, codes_next;
  logic [pcxl_pkg::RUN_W-1:0]        pend, pend_e, pend_next;
  logic                              sig_ok, sig_ok_e, sig_ok_next;

  logic                              accept;
  logic                              sig_now;
  logic [pcxl_pkg::SIZE_W-1:0]       w_full, h_full;
  logic                              too_big;
  logic [2*pcxl_pkg::DIM_W-1:0]      area;
  logic [pcxl_pkg::CODE_W-1:0]       codes_inc;
  logic                              is_run;
  logic [pcxl_pkg::PIX_W-1:0]        pix_dec, pix_run;
  logic [pcxl_pkg::RUN_W-1:0]        run_cnt;
  logic                              code_done, run_done, pal_fin;

  assign src_stall = q_status.full;
  assign accept    = src_valid && !src_stall;

  // state as seen by this item: a file start restarts parsing
  always_comb begin
    if (start_of_file) begin
      phase_e    = pcxl_pkg::PH_HEADER;
      pos_e      = '0;
      img_w_e    = '0;
      img_h_e    = '0;
      pix_left_e = '0;
      codes_e    = '0;
      pend_e     = '0;
      sig_ok_e   = 1'b1;
    end else begin
      phase_e    = phase;
      pos_e      = pos;
      img_w_e    = img_w;
      img_h_e    = img_h;
      pix_left_e = pix_left;
      codes_e    = codes;
      pend_e     = pend;
      sig_ok_e   = sig_ok;
    end
  end

  // byte classification and counters
  always_comb begin
    sig_now   = sig_ok_e && (byte_value == pcxl_pkg::SIG_WORD[pos_e[1:0]*8 +: 8]);
    w_full    = pcxl_pkg::SIZE_W'({byte_value, img_w_e[7:0]}) + pcxl_pkg::SIZE_W'(1);
    h_full    = pcxl_pkg::SIZE_W'({byte_value, img_h_e[7:0]}) + pcxl_pkg::SIZE_W'(1);
    too_big   = (img_w_e > pcxl_pkg::SIZE_W'(pcxl_pkg::MAX_DIM)) ||
                (h_full > pcxl_pkg::SIZE_W'(pcxl_pkg::MAX_DIM));
    area      = img_w_e[pcxl_pkg::DIM_W-1:0] * img_h_e[pcxl_pkg::DIM_W-1:0];
    codes_inc = codes_e + pcxl_pkg::CODE_W'(1);
    is_run    = (byte_value[7:6] == pcxl_pkg::RUN_MARK);
    pix_dec   = pix_left_e - pcxl_pkg::PIX_W'(1);
    run_cnt   = (pcxl_pkg::PIX_W'(pend_e) > pix_left_e) ?
                pix_left_e[pcxl_pkg::RUN_W-1:0] : pend_e;
    pix_run   = pix_left_e - pcxl_pkg::PIX_W'(run_cnt);
    code_done = (pix_dec == '0) || (codes_inc >= pcxl_pkg::CODE_W'(pcxl_pkg::MAX_CODES));
    run_done  = (pix_run == '0) || (codes_e >= pcxl_pkg::CODE_W'(pcxl_pkg::MAX_CODES));
    pal_fin   = (pos_e >= pcxl_pkg::POS_PAL_END);
  end

  // next phase
  always_comb begin
    phase_next = phase_e;
    unique case (phase_e)
      pcxl_pkg::PH_IDLE: phase_next = pcxl_pkg::PH_IDLE;
      pcxl_pkg::PH_HEADER: begin
        if (pos_e == pcxl_pkg::POS_SIG_END && !sig_now) begin
          phase_next = pcxl_pkg::PH_IDLE;
        end else if (pos_e == pcxl_pkg::POS_YHI && too_big) begin
          phase_next = pcxl_pkg::PH_IDLE;
        end else if (pos_e >= pcxl_pkg::POS_HDR_END) begin
          phase_next = pcxl_pkg::PH_CODE;
        end
      end
      pcxl_pkg::PH_CODE: begin
        if (is_run) begin
          phase_next = pcxl_pkg::PH_VALUE;
        end else begin
          phase_next = code_done ? pcxl_pkg::PH_SKIP : pcxl_pkg::PH_CODE;
        end
      end
      pcxl_pkg::PH_VALUE: phase_next = run_done ? pcxl_pkg::PH_SKIP : pcxl_pkg::PH_CODE;
      pcxl_pkg::PH_SKIP: phase_next = pcxl_pkg::PH_PALETTE;
      pcxl_pkg::PH_PALETTE: phase_next = pal_fin ? pcxl_pkg::PH_IDLE : pcxl_pkg::PH_PALETTE;
      default: phase_next = pcxl_pkg::PH_IDLE;
    endcase
  end

  // register updates and commands for the queue
  always_comb begin
    pos_next      = pos_e;
    img_w_next    = img_w_e;
    img_h_next    = img_h_e;
    pix_left_next = pix_left_e;
    codes_next    = codes_e;
    pend_next     = pend_e;
    sig_ok_next   = sig_ok_e;
    cmd_wr        = 1'b0;
    cmd.kind      = pcxl_pkg::K_PIXEL;
    cmd.value     = byte_value;
    cmd.width     = '0;
    cmd.height    = '0;
    cmd.cnt       = pcxl_pkg::RUN_W'(1);
    cmd.last      = 1'b1;
    unique case (phase_e)
      pcxl_pkg::PH_IDLE: begin
        cmd_wr = 1'b0;
      end
      pcxl_pkg::PH_HEADER: begin
        pos_next = pos_e + pcxl_pkg::POS_W'(1);
        if (pos_e <= pcxl_pkg::POS_SIG_END) begin
          sig_ok_next = sig_now;
          if (pos_e == pcxl_pkg::POS_SIG_END && !sig_now) begin
            cmd_wr    = accept;
            cmd.kind  = pcxl_pkg::K_BADSIG;
            cmd.value = '0;
            cmd.last  = 1'b0;
          end
        end else if (pos_e == pcxl_pkg::POS_XLO) begin
          img_w_next = pcxl_pkg::SIZE_W'(byte_value);
        end else if (pos_e == pcxl_pkg::POS_XHI) begin
          img_w_next = w_full;
        end else if (pos_e == pcxl_pkg::POS_YLO) begin
          img_h_next = pcxl_pkg::SIZE_W'(byte_value);
        end else if (pos_e == pcxl_pkg::POS_YHI) begin
          img_h_next = h_full;
          cmd_wr     = accept;
          cmd.kind   = too_big ? pcxl_pkg::K_TOOBIG : pcxl_pkg::K_HEADER;
          cmd.value  = '0;
          cmd.width  = img_w_e;
          cmd.height = h_full;
          cmd.last   = 1'b0;
        end
        if (pos_e >= pcxl_pkg::POS_HDR_END) begin
          pix_left_next = area[pcxl_pkg::PIX_W-1:0];
          codes_next    = '0;
          pos_next      = '0;
        end
      end
      pcxl_pkg::PH_CODE: begin
        codes_next = codes_inc;
        if (is_run) begin
          pend_next = byte_value[pcxl_pkg::RUN_W-1:0];
        end else begin
          pix_left_next = pix_dec;
          cmd_wr        = accept;
        end
      end
      pcxl_pkg::PH_VALUE: begin
        pix_left_next = pix_run;
        pend_next     = '0;
        cmd_wr        = accept && (run_cnt != '0);
        cmd.cnt       = run_cnt;
      end
      pcxl_pkg::PH_SKIP: begin
        pos_next = '0;
      end
      pcxl_pkg::PH_PALETTE: begin
        pos_next = pal_fin ? '0 : pos_e + pcxl_pkg::POS_W'(1);
        cmd_wr   = accept;
        cmd.kind = pcxl_pkg::K_PALETTE;
        cmd.last = pal_fin;
      end
      default: begin
        cmd_wr = 1'b0;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= pcxl_pkg::PH_IDLE;
      pos      <= '0;
      img_w    <= '0;
      img_h    <= '0;
      pix_left <= '0;
      codes    <= '0;
      pend     <= '0;
      sig_ok   <= 1'b1;
    end else if (accept) begin
      phase    <= phase_next;
      pos      <= pos_next;
      img_w    <= img_w_next;
      img_h    <= img_h_next;
      pix_left <= pix_left_next;
      codes    <= codes_next;
      pend     <= pend_next;
      sig_ok   <= sig_ok_next;
    end
  end

endmodule

### hdl/pcxl_queue.sv
module pcxl_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  pcxl_pkg::cmd_t      wr_cmd,
  input  logic                rd_en,
  output pcxl_pkg::cmd_t      rd_cmd,
  output pcxl_pkg::q_status_t status
);

  pcxl_pkg::cmd_t               mem [pcxl_pkg::Q_DEPTH];
  logic [pcxl_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [pcxl_pkg::Q_CNT_W-1:0] count;

  assign status.full  = (count == pcxl_pkg::Q_CNT_W'(pcxl_pkg::Q_DEPTH));
  assign status.empty = (count == '0);
  assign rd_cmd       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + pcxl_pkg::Q_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + pcxl_pkg::Q_PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + pcxl_pkg::Q_CNT_W'(1);
        2'b01:   count <= count - pcxl_pkg::Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // no overflow, no underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && status.full))
    else $error("command written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !status.empty)
    else $error("command taken from an empty queue");

endmodule

### hdl/pcxl_back.sv
module pcxl_back (
  input  logic                       clk,
  input  logic                       rst,
  input  pcxl_pkg::q_status_t        q_status,
  input  pcxl_pkg::cmd_t             q_cmd,
  output logic                       q_rd,
  output logic                       dst_valid,
  input  logic                       dst_stall,
  output logic [2:0]                 kind,
  output logic [7:0]                 value,
  output logic [pcxl_pkg::SIZE_W-1:0] width,
  output logic [pcxl_pkg::SIZE_W-1:0] height,
  output logic                       last
);

  pcxl_pkg::cmd_t               cur;
  logic [pcxl_pkg::RUN_W-1:0]   rem;
  logic                         busy;
  logic                         taken, final_one;

  assign taken     = busy && !dst_stall;
  assign final_one = (rem == pcxl_pkg::RUN_W'(1));
  assign q_rd      = !q_status.empty && (!busy || (taken && final_one));

  assign dst_valid = busy;
  assign kind      = cur.kind;
  assign value     = cur.value;
  assign width     = cur.width;
  assign height    = cur.height;
  assign last      = cur.last && final_one;

  // run expansion: hold a command until its count is used up
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem  <= '0;
    end else if (q_rd) begin
      busy <= 1'b1;
      rem  <= q_cmd.cnt;
    end else if (taken) begin
      rem <= rem - pcxl_pkg::RUN_W'(1);
      if (final_one) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_cmd;
    end
  end

  // a held command always has items left
  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem != '0)
    else $error("output busy with no items left");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && dst_stall) |=> busy && $stable(cur) && $stable(rem))
    else $error("stalled output item changed");

endmodule

### hdl/pcx_rle_image_loader.sv
// path: a taken byte's command is written into the command queue and is then loaded
//   into the output stage register, which offers it as the result
// throughput: one input byte per cycle while the queue is not full; a run of n
//   pixels gives n output items while the four-entry command queue keeps taking
//   bytes until it fills
// reset: synchronous, clears the parser to waiting for a file start and empties
//   the queue and output stage
module pcx_rle_image_loader (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       src_valid,
  output logic                       src_stall,
  input  logic                       start_of_file,
  input  logic [7:0]                 byte_value,
  output logic                       dst_valid,
  input  logic                       dst_stall,
  output logic [2:0]                 kind,
  output logic [7:0]                 value,
  output logic [pcxl_pkg::SIZE_W-1:0] width,
  output logic [pcxl_pkg::SIZE_W-1:0] height,
  output logic                       last
);

  pcxl_pkg::q_status_t q_status;
  pcxl_pkg::cmd_t      wr_cmd, rd_cmd;
  logic                cmd_wr, cmd_rd;

  // header parse and code classification
  pcxl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .src_valid     (src_valid),
    .src_stall     (src_stall),
    .start_of_file (start_of_file),
    .byte_value    (byte_value),
    .q_status      (q_status),
    .cmd_wr        (cmd_wr),
    .cmd           (wr_cmd)
  );

  // commands between parser and expander
  pcxl_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_wr),
    .wr_cmd (wr_cmd),
    .rd_en  (cmd_rd),
    .rd_cmd (rd_cmd),
    .status (q_status)
  );

  // run expansion and output stage
  pcxl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_cmd     (rd_cmd),
    .q_rd      (cmd_rd),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .kind      (kind),
    .value     (value),
    .width     (width),
    .height    (height),
    .last      (last)
  );

endmodule

### bench/tb_pcx_rle_image_loader.sv
`timescale 1ns / 1ps

module tb_pcx_rle_image_loader;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int FIFO_DEPTH   = 32;
  localparam int MAX_REPORTS  = 20;

  typedef struct packed {
    logic       sof;
    logic [7:0] b;
  } file_byte_t;

  typedef struct packed {
    pcxl_pkg::kind_t             kind;
    logic [7:0]                  value;
    logic [pcxl_pkg::SIZE_W-1:0] width;
    logic [pcxl_pkg::SIZE_W-1:0] height;
    logic                        last;
  } decoded_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        src_valid = 1'b0;
  logic                        src_stall;
  logic                        start_of_file = 1'b0;
  logic [7:0]                  byte_value = 8'h00;
  logic                        dst_valid;
  logic                        dst_stall = 1'b0;
  logic [2:0]                  out_kind;
  logic [7:0]                  out_value;
  logic [pcxl_pkg::SIZE_W-1:0] out_width;
  logic [pcxl_pkg::SIZE_W-1:0] out_height;
  logic                        out_last;

  // bytes waiting to be driven and results the decoder should give
  file_byte_t byte_fifo[$];
  decoded_t   decoded_fifo[$];
  file_byte_t next_byte;
  decoded_t   want;

  int  src_idle_pct = 0;
  int  dst_idle_pct = 0;
  bit  src_taken = 1'b0;
  int  cycle_count = 0;
  int  errors = 0;
  int  bytes_taken = 0;
  int  files_started = 0;
  int  results_seen = 0;

  // decoder state kept by the bench
  pcxl_pkg::phase_t            dec_phase;
  logic [pcxl_pkg::POS_W-1:0]  dec_pos;
  logic [pcxl_pkg::SIZE_W-1:0] dec_w;
  logic [pcxl_pkg::SIZE_W-1:0] dec_h;
  logic [pcxl_pkg::PIX_W-1:0]  dec_pix_left;
  logic [pcxl_pkg::CODE_W-1:0] dec_codes;
  logic [pcxl_pkg::RUN_W-1:0]  dec_run;
  logic                        dec_sig_ok;

  pcx_rle_image_loader u_dut (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .start_of_file(start_of_file),
    .byte_value   (byte_value),
    .dst_valid    (dst_valid),
    .dst_stall    (dst_stall),
    .kind         (out_kind),
    .value        (out_value),
    .width        (out_width),
    .height       (out_height),
    .last         (out_last)
  );

  always #4 clk = ~clk;

  task automatic clear_decoder();
    dec_phase    = pcxl_pkg::PH_IDLE;
    dec_pos      = '0;
    dec_w        = '0;
    dec_h        = '0;
    dec_pix_left = '0;
    dec_codes    = '0;
    dec_run      = '0;
    dec_sig_ok   = 1'b1;
  endtask

  task automatic push_decoded(input pcxl_pkg::kind_t k, input logic [7:0] v,
                              input logic [pcxl_pkg::SIZE_W-1:0] w,
                              input logic [pcxl_pkg::SIZE_W-1:0] h,
                              input logic l);
    decoded_t r;
    r.kind   = k;
    r.value  = v;
    r.width  = w;
    r.height = h;
    r.last   = l;
    decoded_fifo.push_back(r);
  endtask

  // decoding ends on the last pixel or on the code limit
  task automatic close_code();
    if (dec_pix_left == 0 || dec_codes >= pcxl_pkg::MAX_CODES)
      dec_phase = pcxl_pkg::PH_SKIP;
    else
      dec_phase = pcxl_pkg::PH_CODE;
  endtask

  // expected results of one accepted file byte
  task automatic decode_byte(input logic sof, input logic [7:0] b);
    int run;
    int i;
    if (sof) begin
      clear_decoder();
      dec_phase = pcxl_pkg::PH_HEADER;
    end
    case (dec_phase)
      pcxl_pkg::PH_HEADER: begin
        if (dec_pos <= pcxl_pkg::POS_SIG_END) begin
          if (b != pcxl_pkg::SIG_WORD[{dec_pos[1:0], 3'b000} +: 8])
            dec_sig_ok = 1'b0;
          if (dec_pos == pcxl_pkg::POS_SIG_END && !dec_sig_ok) begin
            push_decoded(pcxl_pkg::K_BADSIG, '0, '0, '0, 1'b0);
            dec_phase = pcxl_pkg::PH_IDLE;
            return;
          end
        end else if (dec_pos == pcxl_pkg::POS_XLO) begin
          dec_w = pcxl_pkg::SIZE_W'(b);
        end else if (dec_pos == pcxl_pkg::POS_XHI) begin
          dec_w = {1'b0, b, dec_w[7:0]} + 1'b1;
        end else if (dec_pos == pcxl_pkg::POS_YLO) begin
          dec_h = pcxl_pkg::SIZE_W'(b);
        end else if (dec_pos == pcxl_pkg::POS_YHI) begin
          dec_h = {1'b0, b, dec_h[7:0]} + 1'b1;
          if (dec_w > pcxl_pkg::MAX_DIM || dec_h > pcxl_pkg::MAX_DIM) begin
            push_decoded(pcxl_pkg::K_TOOBIG, '0, dec_w, dec_h, 1'b0);
            dec_phase = pcxl_pkg::PH_IDLE;
            return;
          end
          push_decoded(pcxl_pkg::K_HEADER, '0, dec_w, dec_h, 1'b0);
        end
        if (dec_pos >= pcxl_pkg::POS_HDR_END) begin
          dec_pix_left = dec_w * dec_h;
          dec_codes    = '0;
          dec_pos      = '0;
          dec_phase    = pcxl_pkg::PH_CODE;
        end else begin
          dec_pos = dec_pos + 1'b1;
        end
      end
      pcxl_pkg::PH_CODE: begin
        dec_codes = dec_codes + 1'b1;
        if (b[7:6] != pcxl_pkg::RUN_MARK) begin
          push_decoded(pcxl_pkg::K_PIXEL, b, '0, '0, 1'b1);
          dec_pix_left = dec_pix_left - 1'b1;
          close_code();
        end else begin
          dec_run   = b[pcxl_pkg::RUN_W-1:0];
          dec_phase = pcxl_pkg::PH_VALUE;
        end
      end
      pcxl_pkg::PH_VALUE: begin
        // a run is clipped to the pixels still missing
        run = (dec_run > dec_pix_left) ? int'(dec_pix_left) : int'(dec_run);
        for (i = 0; i < run; i++)
          push_decoded(pcxl_pkg::K_PIXEL, b, '0, '0, i + 1 == run);
        dec_pix_left = dec_pix_left - pcxl_pkg::PIX_W'(run);
        dec_run      = '0;
        close_code();
      end
      pcxl_pkg::PH_SKIP: begin
        dec_pos   = '0;
        dec_phase = pcxl_pkg::PH_PALETTE;
      end
      pcxl_pkg::PH_PALETTE: begin
        push_decoded(pcxl_pkg::K_PALETTE, b, '0, '0, dec_pos >= pcxl_pkg::POS_PAL_END);
        if (dec_pos >= pcxl_pkg::POS_PAL_END) begin
          dec_pos   = '0;
          dec_phase = pcxl_pkg::PH_IDLE;
        end else begin
          dec_pos = dec_pos + 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name,
                               input logic [pcxl_pkg::SIZE_W-1:0] exp_v,
                               input logic [pcxl_pkg::SIZE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // sender: next item on the falling edge once the current one has gone
  always @(negedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      dst_stall <= 1'b0;
    end else begin
      if (!src_valid || src_taken) begin
        if (byte_fifo.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_byte = byte_fifo.pop_front();
          start_of_file <= next_byte.sof;
          byte_value    <= next_byte.b;
          src_valid     <= 1'b1;
        end else begin
          src_valid <= 1'b0;
        end
      end
      dst_stall <= ($urandom_range(0, 99) < dst_idle_pct);
    end
  end

  // monitor: predict on every taken byte, check every taken result
  always @(posedge clk) begin
    cycle_count++;
    src_taken = !rst && src_valid && !src_stall;
    if (src_taken) begin
      bytes_taken++;
      if (start_of_file)
        files_started++;
      decode_byte(start_of_file, byte_value);
    end
    if (!rst && dst_valid && !dst_stall) begin
      results_seen++;
      if (decoded_fifo.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result expected none, got kind %0d value %0d", $time,
                   out_kind, out_value);
      end else begin
        want = decoded_fifo.pop_front();
        compare_field("kind", pcxl_pkg::SIZE_W'(want.kind), pcxl_pkg::SIZE_W'(out_kind));
        compare_field("value", pcxl_pkg::SIZE_W'(want.value), pcxl_pkg::SIZE_W'(out_value));
        compare_field("width", want.width, out_width);
        compare_field("height", want.height, out_height);
        compare_field("last", pcxl_pkg::SIZE_W'(want.last), pcxl_pkg::SIZE_W'(out_last));
      end
    end
  end

  task automatic send_byte(input logic sof, input logic [7:0] b);
    file_byte_t item;
    while (byte_fifo.size() >= FIFO_DEPTH)
      @(posedge clk);
    item.sof = sof;
    item.b   = b;
    byte_fifo.push_back(item);
  endtask

  // any byte that is not a run count
  function automatic logic [7:0] plain_byte();
    logic [7:0] pb;
    pb = 8'($urandom);
    if (pb[7:6] == pcxl_pkg::RUN_MARK)
      pb[7] = 1'b0;
    return pb;
  endfunction

  // first nbytes of a header with the given signature and maximum x and y
  task automatic send_header(input logic [31:0] sig, input logic [15:0] mx,
                             input logic [15:0] my, input int nbytes);
    int i;
    logic [7:0] b;
    for (i = 0; i < nbytes; i++) begin
      if (i <= pcxl_pkg::POS_SIG_END)   b = sig[8*i +: 8];
      else if (i == pcxl_pkg::POS_XLO)  b = mx[7:0];
      else if (i == pcxl_pkg::POS_XHI)  b = mx[15:8];
      else if (i == pcxl_pkg::POS_YLO)  b = my[7:0];
      else if (i == pcxl_pkg::POS_YHI)  b = my[15:8];
      else                              b = 8'($urandom);
      send_byte(i == 0, b);
    end
  endtask

  task automatic send_palette(input int nbytes);
    int i;
    for (i = 0; i < nbytes; i++)
      send_byte(1'b0, 8'($urandom));
  endtask

  // wait until every byte is taken and every result has come
  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (byte_fifo.size() != 0 || (src_valid && !src_taken) || decoded_fifo.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    $display("FAIL pcx_rle_image_loader");
    $finish;
  end

  initial begin
    clear_decoder();
    src_idle_pct = 12;
    dst_idle_pct = 49;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // stray bytes before any file start
    send_byte(1'b0, 8'hff);
    send_byte(1'b0, pcxl_pkg::SIG_WORD[7:0]);
    // bad signature at its first and at its last byte
    send_header(pcxl_pkg::SIG_WORD ^ 32'h0000_00ff, 16'd0, 16'd0, 4);
    send_header(pcxl_pkg::SIG_WORD ^ 32'hff00_0000, 16'd0, 16'd0, 4);
    wait_idle();

    src_idle_pct = 49;
    dst_idle_pct = 12;
    // too large in x only, then in y only at the largest header value
    send_header(pcxl_pkg::SIG_WORD, 16'(pcxl_pkg::MAX_DIM), 16'd0, 12);
    send_header(pcxl_pkg::SIG_WORD, 16'd0, 16'hffff, 12);
    wait_idle();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    // ten by ten image: empty run, single pixel, longest run, clipped run
    send_header(pcxl_pkg::SIG_WORD, 16'd9, 16'd9, pcxl_pkg::HEADER_BYTES);
    send_byte(1'b0, {pcxl_pkg::RUN_MARK, 6'd0});
    send_byte(1'b0, 8'($urandom));
    send_byte(1'b0, plain_byte());
    send_byte(1'b0, {pcxl_pkg::RUN_MARK, 6'd63});
    send_byte(1'b0, 8'($urandom));
    send_byte(1'b0, {pcxl_pkg::RUN_MARK, 6'd40});
    send_byte(1'b0, 8'($urandom));
    // skipped byte, start of the palette, then a restart with a bad signature
    send_byte(1'b0, 8'($urandom));
    send_palette(3);
    send_header(pcxl_pkg::SIG_WORD ^ 32'h0000_ff00, 16'd0, 16'd0, 4);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d file starts, %0d bytes taken, %0d results checked",
             files_started, bytes_taken, results_seen);
    $display("incl. stray bytes, signature and size rejects, empty and clipped runs, restarts");
    if (errors == 0 && decoded_fifo.size() == 0)
      $display("PASS pcx_rle_image_loader");
    else
      $display("FAIL pcx_rle_image_loader");
    $finish;
  end

endmodule
